FILE: hdl/dbf_pkg.sv
`timescale 1ns / 1ps
package dbf_pkg;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_BADCFG   = 2'd2;

  localparam logic [1:0] CFG_FILTER_BITS  = 2'd0;
  localparam logic [1:0] CFG_HASH_COUNT   = 2'd1;
  localparam logic [1:0] CFG_REGION_COUNT = 2'd2;

  localparam logic [31:0] HASH_MULT = 32'd2654435769;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch key, clear accumulators
    logic hash_start; // start hash of probe_idx
    logic probe_rd;   // read filter/region bits; not set by dbf_ctrl nor read by dbf_datapath
    logic ins_mark;   // insert: mark region / count
    logic ins_wr;     // insert: set filter bit of scratch entry
    logic chk;        // membership check with read bits
    logic rem_upd;    // remove: clear bit or count
    logic [5:0] probe_idx;
  } dbf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hash_done;
    logic present;
  } dbf_stat_t;
endpackage

FILE: hdl/dbf_ram.sv
`timescale 1ns / 1ps
module dbf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/dbf_hash.sv
`timescale 1ns / 1ps
// Multi-cycle probe hash: 64x32 multiply as two 32x32 partial products,
// then restoring mod m and restoring divide of h*r by m, one bit per cycle.
module dbf_hash #(
  parameter int IW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [5:0]    probe,
  input  logic [31:0]   key,
  input  logic [12:0]   m,
  input  logic [12:0]   r,
  output logic          done,
  output logic [IW-1:0] h,
  output logic [IW-1:0] reg_idx
);
  import dbf_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_MLO = 3'd1, S_MHI = 3'd2, S_SUM = 3'd3,
                         S_MOD = 3'd4, S_RMUL = 3'd5, S_DIV = 3'd6, S_DONE = 3'd7;
  logic [2:0]  st_r, st_nxt;
  logic [31:0] hi_w;
  logic [63:0] plo_r, plo_nxt;
  logic [31:0] phi_r, phi_nxt;
  logic [31:0] rem_r, rem_nxt;  // shifting dividend
  logic [12:0] acc_r, acc_nxt;  // partial remainder
  logic [5:0]  cnt_r, cnt_nxt;
  logic [25:0] quo_r, quo_nxt;
  logic [13:0] trial;
  logic [IW-1:0] h_r, h_nxt;

  assign hi_w = key[31] ? 32'hFFFF_FFFF : {26'd0, probe};
  assign trial = {acc_r, rem_r[31]} - {1'b0, m};

  always_comb begin
    st_nxt = st_r; plo_nxt = plo_r; phi_nxt = phi_r; rem_nxt = rem_r;
    acc_nxt = acc_r; cnt_nxt = cnt_r; quo_nxt = quo_r; h_nxt = h_r;
    case (st_r)
      S_IDLE: if (start) st_nxt = S_MLO;
      S_MLO: begin
        plo_nxt = key * HASH_MULT;
        st_nxt = S_MHI;
      end
      S_MHI: begin
        phi_nxt = 32'(hi_w * HASH_MULT);
        st_nxt = S_SUM;
      end
      S_SUM: begin
        rem_nxt = plo_r[31:0] + (plo_r[63:32] + phi_r);
        acc_nxt = '0; cnt_nxt = 6'd32;
        st_nxt = S_MOD;
      end
      S_MOD, S_DIV: begin
        if (!trial[13]) acc_nxt = trial[12:0];
        else acc_nxt = {acc_r[11:0], rem_r[31]};
        rem_nxt = {rem_r[30:0], 1'b0};
        quo_nxt = {quo_r[24:0], ~trial[13]};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) st_nxt = (st_r == S_MOD) ? S_RMUL : S_DONE;
      end
      S_RMUL: begin
        h_nxt = IW'(acc_r);
        rem_nxt = {6'd0, 26'(acc_r * r)};
        acc_nxt = '0; cnt_nxt = 6'd32;
        st_nxt = S_DIV;
      end
      S_DONE: begin
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    plo_r <= plo_nxt; phi_r <= phi_nxt; rem_r <= rem_nxt; acc_r <= acc_nxt;
    cnt_r <= cnt_nxt; quo_r <= quo_nxt; h_r <= h_nxt;
  end

  assign done = (st_r == S_DONE);
  assign h = h_r;
  assign reg_idx = IW'(quo_r);
endmodule

FILE: hdl/dbf_datapath.sv
`timescale 1ns / 1ps
module dbf_datapath #(
  parameter int MAX_BITS = 4096,
  parameter int MAX_HASHES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dbf_pkg::dbf_cmd_t cmd,
  input  logic [31:0]      key,
  input  logic [12:0]      m,
  input  logic [12:0]      r,
  input  logic             clr_we,
  input  logic [$clog2(MAX_BITS)-1:0] clr_addr,
  output dbf_pkg::dbf_stat_t stat,
  output logic [4:0]       count
);
  import dbf_pkg::*;
  localparam int IW = $clog2(MAX_BITS);
  localparam int PW = $clog2(MAX_HASHES) > 0 ? $clog2(MAX_HASHES) : 1;
  logic [31:0] key_r;
  logic [IW-1:0] h, g, h_r, g_r;
  logic hdone;
  logic fbit, rbit;
  logic present_r, present_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic f_we, r_we, f_wd;
  logic [IW-1:0] f_wa, f_ra, r_ra;
  logic [IW-1:0] scr_rd;

  dbf_hash #(.IW(IW)) u_hash (
    .clk, .rst_n, .start(cmd.hash_start), .probe(cmd.probe_idx), .key(key_r),
    .m, .r, .done(hdone), .h, .reg_idx(g)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) key_r <= key;
    if (hdone) begin
      h_r <= h;
      g_r <= IW'(g);
    end
  end

  // hash result is latched at done; the store reads use h_r, g_r after that
  assign f_ra = cmd.ins_wr ? scr_rd : h_r;
  assign r_ra = g_r;

  always_comb begin
    f_we = 1'b0; f_wa = h_r; f_wd = 1'b0; r_we = 1'b0;
    present_nxt = present_r; cnt_nxt = cnt_r;
    if (cmd.load) begin
      present_nxt = 1'b1; cnt_nxt = '0;
    end
    if (cmd.chk && !fbit) present_nxt = 1'b0;
    if (cmd.ins_mark && (fbit || rbit)) begin
      r_we = 1'b1; cnt_nxt = cnt_r + 5'd1;
    end
    if (cmd.ins_wr) begin
      f_we = 1'b1; f_wa = scr_rd; f_wd = 1'b1;
    end
    if (cmd.rem_upd) begin
      if (rbit) cnt_nxt = cnt_r + 5'd1;
      else f_we = 1'b1;
    end
    if (clr_we) begin
      f_we = 1'b1; f_wa = clr_addr; f_wd = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0; cnt_r <= '0;
    end else begin
      present_r <= present_nxt; cnt_r <= cnt_nxt;
    end
  end

  dbf_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_filter (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(fbit)
  );
  dbf_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_region (
    .clk, .we(r_we || clr_we), .waddr(clr_we ? clr_addr : g_r), .wdata(!clr_we),
    .raddr(r_ra), .rdata(rbit)
  );
  // probe index scratch for the deferred filter writes of an insert
  dbf_ram #(.WIDTH(IW), .DEPTH(MAX_HASHES)) u_scratch (
    .clk, .we(cmd.ins_mark), .waddr(PW'(cmd.probe_idx)), .wdata(h_r),
    .raddr(PW'(cmd.probe_idx)), .rdata(scr_rd)
  );

  assign stat.hash_done = hdone;
  assign stat.present = present_r;
  assign count = cnt_r;
endmodule

FILE: hdl/dbf_ctrl.sv
`timescale 1ns / 1ps
module dbf_ctrl #(
  parameter int MAX_BITS = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [1:0]        in_cmd,
  input  logic              cfg_ok,
  input  logic [4:0]        k,
  input  dbf_pkg::dbf_stat_t stat,
  input  logic              out_taken,
  output dbf_pkg::dbf_cmd_t cmd,
  output logic              busy,
  output logic              res_load,
  output logic [1:0]        res_status,
  output logic              res_found,
  output logic              clr_we,
  output logic [$clog2(MAX_BITS)-1:0] clr_addr
);
  import dbf_pkg::*;
  localparam int IW = $clog2(MAX_BITS);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_HASH = 4'd2, S_WAIT = 4'd3,
                         S_RD = 4'd4, S_ACT = 4'd5, S_WRD = 4'd6, S_WR = 4'd7,
                         S_RES = 4'd8, S_OUT = 4'd9;
  logic [3:0] st_r, st_nxt;
  logic [1:0] op_r, op_nxt;
  logic [5:0] pi_r, pi_nxt;
  logic       pass_r, pass_nxt; // remove: 0 = check, 1 = update
  logic [IW-1:0] ca_r, ca_nxt;
  logic last;

  assign last = (pi_r == 6'(k - 5'd1));

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; pi_nxt = pi_r; pass_nxt = pass_r; ca_nxt = ca_r;
    cmd = '0; cmd.probe_idx = pi_r;
    res_load = 1'b0; res_status = ST_OK; res_found = 1'b0; clr_we = 1'b0;
    case (st_r)
      S_CLR: begin
        clr_we = 1'b1; ca_nxt = ca_r + 1'b1;
        if (&ca_r) st_nxt = S_IDLE;
      end
      S_IDLE: if (in_fire) begin
        op_nxt = in_cmd; pi_nxt = '0; pass_nxt = 1'b0; cmd.load = 1'b1;
        if (in_cmd == CMD_UNUSED) st_nxt = S_RES;
        else if (!cfg_ok) st_nxt = S_RES;
        else st_nxt = S_HASH;
      end
      S_HASH: begin
        cmd.hash_start = 1'b1; st_nxt = S_WAIT;
      end
      S_WAIT: if (stat.hash_done) st_nxt = S_RD;
      S_RD: st_nxt = S_ACT;
      S_ACT: begin
        if (op_r == CMD_INSERT) cmd.ins_mark = 1'b1;
        else if (pass_r) cmd.rem_upd = 1'b1;
        else cmd.chk = 1'b1;
        st_nxt = S_HASH; pi_nxt = pi_r + 6'd1;
        if (last) begin
          pi_nxt = '0;
          if (op_r == CMD_INSERT) st_nxt = S_WRD;
          else if (op_r == CMD_REMOVE && !pass_r) st_nxt = S_RES;
          else st_nxt = S_RES;
        end
      end
      S_WRD: st_nxt = S_WR; // scratch read latency
      S_WR: begin
        cmd.ins_wr = 1'b1;
        pi_nxt = pi_r + 6'd1;
        st_nxt = last ? S_RES : S_WRD;
      end
      S_RES: begin
        // remove with a present key goes round a second time to update
        if (op_r == CMD_REMOVE && cfg_ok && !pass_r && stat.present) begin
          pass_nxt = 1'b1; st_nxt = S_HASH;
        end else begin
          res_load = 1'b1; st_nxt = S_OUT;
          if (op_r != CMD_UNUSED && !cfg_ok) res_status = ST_BADCFG;
          else if (op_r == CMD_REMOVE && !pass_r) res_status = ST_NOTFOUND;
          res_found = (op_r == CMD_QUERY) && cfg_ok && stat.present;
        end
      end
      S_OUT: if (out_taken) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // in S_WR the scratch address must point at the entry read in S_WRD
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; op_r <= '0; pi_r <= '0; pass_r <= 1'b0; ca_r <= '0;
    end else begin
      st_r <= st_nxt; op_r <= op_nxt; pi_r <= pi_nxt; pass_r <= pass_nxt; ca_r <= ca_nxt;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign clr_addr = ca_r;
endmodule

FILE: hdl/deletable_bloom_filter_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields (tdata low bit up)
// in_      in   cmd[1:0], key[33:2]                (40 bits)
// out_     out  status[1:0], found[2], count[7:3]  (8 bits)
// cfg_     in   index 0 filter_bits, 1 hash_count, 2 region_count
// One item at a time. Each probe runs through the hash unit (two partial
// products, a sum, a 32-step mod, a multiply and a 32-step divide), then
// reads and acts on its filter and region bits; an insert adds deferred
// filter writes and a present remove goes over all probes a second time.
// After reset a clearing pass over every filter and region address runs
// before in_tready rises. The result sits in the output register until
// taken; no input is taken meanwhile.
module deletable_bloom_filter_core #(
  parameter int MAX_BITS = 4096,
  parameter int MAX_HASHES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd, key
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // status, found, collision_count
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import dbf_pkg::*;
  localparam int IW = $clog2(MAX_BITS);
  logic [12:0] m_r; logic [4:0] k_r; logic [12:0] r_r;
  logic cfg_ok, busy, in_fire, res_load, res_found, clr_we, ov_r;
  logic [1:0] res_status;
  logic [IW-1:0] clr_addr;
  logic [4:0] count;
  logic [7:0] od_r;
  dbf_cmd_t cmd;
  dbf_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= 13'd1024; k_r <= 5'd4; r_r <= 13'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_BITS:  m_r <= cfg_data;
        CFG_HASH_COUNT:   k_r <= cfg_data[4:0];
        CFG_REGION_COUNT: r_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ok = (m_r != 0) && (32'(m_r) <= MAX_BITS) && (k_r != 0) &&
                  (32'(k_r) <= MAX_HASHES) && (r_r != 0) && (r_r <= m_r);
  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;

  dbf_ctrl #(.MAX_BITS(MAX_BITS)) u_ctrl (
    .clk, .rst_n, .in_fire, .in_cmd(in_tdata[1:0]), .cfg_ok, .k(k_r), .stat,
    .out_taken(out_tvalid && out_tready), .cmd, .busy, .res_load, .res_status,
    .res_found, .clr_we, .clr_addr
  );
  dbf_datapath #(.MAX_BITS(MAX_BITS), .MAX_HASHES(MAX_HASHES)) u_dp (
    .clk, .rst_n, .cmd, .key(in_tdata[33:2]), .m(m_r), .r(r_r), .clr_we, .clr_addr,
    .stat, .count
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (res_load) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
    if (res_load)
      od_r <= {(res_status == ST_OK && res_found == 1'b0) ? count : 5'd0,
               res_found, res_status};
  end
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
endmodule

FILE: sim/deletable_bloom_filter_core_tb.sv
`timescale 1ns / 1ps
module deletable_bloom_filter_core_tb;
  import dbf_pkg::*;

  localparam int MAX_BITS = 4096;
  localparam int MAX_HASHES = 16;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [4:0] collisions;
  } bloom_answer_t;

  class bloom_scoreboard;
    bit filter_mem[MAX_BITS];
    bit region_mem[MAX_BITS];
    int unsigned m_bits, k_hashes, r_regions;
    bloom_answer_t answers_due[$];
    int fail_count;
    int n_insert, n_query, n_remove, n_absent, n_badcfg, n_hits, n_collide;

    function new();
      m_bits = 1024;
      k_hashes = 4;
      r_regions = 64;
      fail_count = 0;
      foreach (filter_mem[i]) begin
        filter_mem[i] = 0;
        region_mem[i] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        CFG_FILTER_BITS:  m_bits = val;
        CFG_HASH_COUNT:   k_hashes = val[4:0];
        CFG_REGION_COUNT: r_regions = val;
        default: ;
      endcase
    endfunction

    function bit cfg_valid();
      return m_bits >= 1 && m_bits <= MAX_BITS && k_hashes >= 1 &&
             k_hashes <= MAX_HASHES && r_regions >= 1 && r_regions <= m_bits;
    endfunction

    function int unsigned slot_of(int unsigned probe, logic [31:0] key);
      logic [63:0] word, prod;
      logic [31:0] sum;
      word = {probe[31:0], key};
      if (key[31]) word[63:32] = '1;
      prod = word * {32'd0, HASH_MULT};
      sum = prod[31:0] + prod[63:32];
      return sum % m_bits;
    endfunction

    function int unsigned region_of(int unsigned h);
      logic [31:0] p;
      p = h * r_regions;
      return p / m_bits;
    endfunction

    function bit holds(logic [31:0] key);
      for (int i = 0; i < k_hashes; i++)
        if (!filter_mem[slot_of(i, key)]) return 0;
      return 1;
    endfunction

    // one beat in: work out its answer and update the filter copy
    function void note_input(logic [1:0] cmd, logic [31:0] key);
      bloom_answer_t a;
      int unsigned h, rg;
      int unsigned slots[MAX_HASHES];
      a = '0;
      if (cmd != CMD_UNUSED && !cfg_valid()) begin
        a.status = ST_BADCFG;
        n_badcfg++;
      end else if (cmd == CMD_INSERT) begin
        n_insert++;
        for (int i = 0; i < k_hashes; i++) begin
          h = slot_of(i, key);
          rg = region_of(h);
          slots[i] = h;
          if (filter_mem[h] || region_mem[rg]) begin
            region_mem[rg] = 1;
            a.collisions++;
          end
        end
        for (int i = 0; i < k_hashes; i++) filter_mem[slots[i]] = 1;
      end else if (cmd == CMD_QUERY) begin
        n_query++;
        a.found = holds(key);
        if (a.found) n_hits++;
      end else if (cmd == CMD_REMOVE) begin
        n_remove++;
        if (!holds(key)) begin
          a.status = ST_NOTFOUND;
          n_absent++;
        end else begin
          for (int i = 0; i < k_hashes; i++) begin
            h = slot_of(i, key);
            if (region_mem[region_of(h)]) a.collisions++;
            else filter_mem[h] = 0;
          end
        end
      end
      if (a.collisions != 0) n_collide++;
      answers_due.push_back(a);
    endfunction

    function void check_result(logic [7:0] data);
      bloom_answer_t got, want;
      got = {data[1:0], data[2], data[7:3]};
      if (answers_due.size() == 0) begin
        $error("unexpected result beat %h", data);
        fail_count++;
        return;
      end
      want = answers_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        fail_count++;
      end
      if (got.collisions !== want.collisions) begin
        $error("collision_count: expected %0d, got %0d", want.collisions, got.collisions);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [7:0] out_tdata;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;

  bloom_scoreboard sb = new();
  bit calm = 0;
  longint cycles = 0;
  logic [31:0] key_pool[$];

  deletable_bloom_filter_core #(.MAX_BITS(MAX_BITS), .MAX_HASHES(MAX_HASHES)) uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= calm || ($urandom_range(99) >= 31);

  always @(posedge clk) if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);

  task automatic send_beat(logic [1:0] cmd, logic [31:0] key);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 31) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'd0, key, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, key);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    while (sb.answers_due.size() != 0) @(posedge clk);
  endtask

  // drains first, so the registers are written only once the block has nothing in flight
  task automatic set_cfg(logic [12:0] m, logic [12:0] k, logic [12:0] r);
    logic [12:0] vals[3];
    logic [1:0] idx[3];
    vals = '{m, k, r};
    idx = '{CFG_FILTER_BITS, CFG_HASH_COUNT, CFG_REGION_COUNT};
    drain();
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_we <= 1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    @(negedge clk);
    cfg_we <= 0;
    key_pool.delete();
  endtask

  // mostly inserts of fresh keys and lookup/remove of keys already in play, some noise
  task automatic random_run(int n);
    int pick;
    logic [1:0] cmd;
    logic [31:0] key;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 38) cmd = CMD_INSERT;
      else if (pick < 66) cmd = CMD_QUERY;
      else if (pick < 94) cmd = CMD_REMOVE;
      else cmd = CMD_UNUSED;
      if (key_pool.size() != 0 && cmd != CMD_INSERT && $urandom_range(99) < 75)
        key = key_pool[$urandom_range(key_pool.size() - 1)];
      else if (key_pool.size() != 0 && $urandom_range(99) < 15)
        key = key_pool[$urandom_range(key_pool.size() - 1)];
      else key = $urandom;
      if (cmd == CMD_INSERT) key_pool.push_back(key);
      send_beat(cmd, key);
    end
  endtask

  initial begin
    logic [31:0] edge_keys[4];
    edge_keys = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: reset config, extreme keys, all commands, absent remove
    send_beat(CMD_REMOVE, 32'h0);
    foreach (edge_keys[i]) send_beat(CMD_INSERT, edge_keys[i]);
    foreach (edge_keys[i]) send_beat(CMD_QUERY, edge_keys[i]);
    send_beat(CMD_QUERY, 32'h1234_5678);
    send_beat(CMD_UNUSED, 32'hA5A5_A5A5);
    foreach (edge_keys[i]) send_beat(CMD_REMOVE, edge_keys[i]);
    send_beat(CMD_REMOVE, 32'h5A5A_5A5A);
    set_cfg(13'd4096, 13'd16, 13'd4096);
    send_beat(CMD_INSERT, 32'h8000_0000);
    send_beat(CMD_REMOVE, 32'h8000_0000);
    set_cfg(13'd1, 13'd1, 13'd1);
    send_beat(CMD_INSERT, 32'h7FFF_FFFF);
    send_beat(CMD_QUERY, 32'h0);
    send_beat(CMD_REMOVE, 32'hFFFF_FFFF);
    // bad configurations: region above bits, zero and oversized fields
    set_cfg(13'd100, 13'd4, 13'd200);
    send_beat(CMD_INSERT, 32'h1);
    send_beat(CMD_UNUSED, 32'h1);
    set_cfg(13'd0, 13'd4, 13'd0);
    send_beat(CMD_QUERY, 32'h1);
    set_cfg(13'd4097, 13'd17, 13'd8);
    send_beat(CMD_REMOVE, 32'h1);
    set_cfg(13'd64, 13'd0, 13'd8);
    send_beat(CMD_INSERT, 32'h2);

    set_cfg(13'd1024, 13'd4, 13'd64);
    random_run(80);
    drain();
    random_run(40);
    set_cfg(13'd16, 13'd3, 13'd4);
    random_run(70);
    calm = 1;
    set_cfg(13'd64, 13'd8, 13'd64);
    random_run(60);
    calm = 0;
    set_cfg(13'd4096, 13'd1, 13'd1);
    random_run(60);
    set_cfg(13'd200, 13'd2, 13'd13);
    random_run(80);
    set_cfg(13'd4096, 13'd16, 13'd4096);
    random_run(15);
    set_cfg(13'd50, 13'd5, 13'd51);
    random_run(5);
    set_cfg(13'd512, 13'd5, 13'd17);
    random_run(40);

    drain();
    repeat (300) @(posedge clk);
    $display("covered %0d inserts, %0d queries (%0d hits), %0d removes (%0d absent)",
             sb.n_insert, sb.n_query, sb.n_hits, sb.n_remove, sb.n_absent);
    $display("%0d answers with collisions, %0d bad-config answers, %0d config settings",
             sb.n_collide, sb.n_badcfg, 14);
    if (sb.fail_count == 0 && sb.answers_due.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

FILE: files.f
hdl/dbf_pkg.sv
hdl/dbf_ram.sv
hdl/dbf_hash.sv
hdl/dbf_datapath.sv
hdl/dbf_ctrl.sv
hdl/deletable_bloom_filter_core.sv
sim/deletable_bloom_filter_core_tb.sv
